>>> hw/rtl/mixed_voronoi_triangle_weights_macros.svh
// Assertion macros shared by the checker of the triangle weight block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIXED_VORONOI_TRIANGLE_WEIGHTS_MACROS_SVH
`define MIXED_VORONOI_TRIANGLE_WEIGHTS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MVTW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mvtw: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define MVTW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mvtw: next-cycle check failed");

`endif

>>> hw/rtl/mvtw_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the mixed Voronoi triangle weight block.
// No dependencies; imported by the top level, the divider and the checker.
package mvtw_pkg;

	// width of every area and weight result field
	localparam int OUT_W = 48;

	// corner codes carried in the obtuse corner field
	typedef logic [1:0] corner_t;
	localparam corner_t CORNER_0    = 2'd0;
	localparam corner_t CORNER_1    = 2'd1;
	localparam corner_t CORNER_2    = 2'd2;
	localparam corner_t CORNER_NONE = 2'd3;

	// number of coordinate fields in one input transfer
	localparam int N_COORDS = 9;

endpackage

>>> hw/rtl/mvtw_mul.sv
`timescale 1ns / 1ps
// Two-stage unsigned multiplier built from four half-width partial products.
// No dependencies; instanced by the top level.
module mvtw_mul #(
	parameter int W = 50
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);

	localparam int HL = W / 2;
	localparam int HH = W - HL;

	logic [HL-1:0]    a_lo, b_lo;
	logic [HH-1:0]    a_hi, b_hi;
	logic [2*HL-1:0]  pp_ll_s1;
	logic [HL+HH-1:0] pp_lh_s1, pp_hl_s1;
	logic [2*HH-1:0]  pp_hh_s1;
	logic [2*W-1:0]   p_s2;

	assign a_lo = a[HL-1:0];
	assign a_hi = a[W-1:HL];
	assign b_lo = b[HL-1:0];
	assign b_hi = b[W-1:HL];

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a_lo * b_lo;
			pp_lh_s1 <= a_lo * b_hi;
			pp_hl_s1 <= a_hi * b_lo;
			pp_hh_s1 <= a_hi * b_hi;
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ((2*W)'(pp_hh_s1) << (2*HL)) + ((2*W)'(pp_lh_s1) << HL)
				+ ((2*W)'(pp_hl_s1) << HL) + (2*W)'(pp_ll_s1);
		end
	end

	assign p = p_s2;

endmodule

>>> hw/rtl/mvtw_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on mvtw_pkg; instanced by the top level.
module mvtw_div #(
	parameter int ZW = 88,
	parameter int DW = 51
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ZW-1:0]            num,
	input  logic [DW-1:0]            den,
	output logic [mvtw_pkg::OUT_W-1:0] quo
);
	import mvtw_pkg::*;

	localparam int CMW = (ZW > DW + OUT_W) ? ZW : DW + OUT_W;

	logic [ZW-1:0]    rem_s [0:OUT_W];
	logic [DW-1:0]    den_s [0:OUT_W];
	logic [OUT_W-1:0] quo_s [0:OUT_W];
	logic             ovf_s [0:OUT_W];

	// entry: quotient would not fit in OUT_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= CMW'(num) >= (CMW'(den) << OUT_W);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= OUT_W; j++) begin : g_step
		localparam int K = OUT_W - j;
		logic [CMW-1:0] dsh;
		logic           ge;

		assign dsh = CMW'(den_s[j-1]) << K;
		assign ge  = CMW'(rem_s[j-1]) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? ZW'(CMW'(rem_s[j-1]) - dsh) : rem_s[j-1];
				den_s[j] <= den_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				quo_s[j] <= quo_s[j-1] | (ge ? (OUT_W'(1) << K) : '0);
			end
		end
	end

	assign quo = ovf_s[OUT_W] ? '1 : quo_s[OUT_W];

endmodule

>>> hw/rtl/mixed_voronoi_triangle_weights.sv
`timescale 1ns / 1ps
// Top level of the mixed Voronoi triangle weight block.
// Depends on mvtw_pkg, mvtw_mul and mvtw_div.
//
// Usage: one triangle (three vertices, signed fixed point) enters per transfer on
// the s_axis channel; one result (area, three corner weights, obtuse corner,
// degenerate flag) leaves per transfer on the m_axis channel, in order.
// Throughput: one triangle per cycle while the skid entry is free. The input
// transfer passes through the front stages, the integer square root (one root
// bit per stage, 2*COORD_WIDTH + 3 stages), the entry stage and 48-stage quotient
// pipeline of the three weight dividers, and then the output register.
// The whole pipeline moves together; a two-entry output (register plus skid) lets
// the input keep taking a transfer while the output result waits. If the receiver
// stalls, the skid fills and s_axis_tready drops until the output is taken; no
// result is lost or repeated.
// Reset clears every valid bit, also those of the output register and skid; no result is pending after it.
module mixed_voronoi_triangle_weights #(
	parameter int COORD_WIDTH     = 24,
	parameter int COORD_FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	// p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (low bits first)
	input  logic [((mvtw_pkg::N_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tri_area, weight_0, weight_1, weight_2 (low bits first)
	output logic [4*mvtw_pkg::OUT_W-1:0] m_axis_tdata,
	// obtuse_corner [1:0], degenerate [2]
	output logic [2:0] m_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready
);
	import mvtw_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = COORD_FRAC_BITS;
	localparam int EW    = CW + 1;
	localparam int PW    = 2 * EW;
	localparam int CRW   = PW + 1;
	localparam int DTW   = PW + 2;
	localparam int MW    = PW;
	localparam int QW    = 2 * MW + 2;
	localparam int RW    = MW + 1;
	localparam int NUMW  = 2 * MW + 1;
	localparam int ZW    = NUMW - F - 3;
	localparam int NXW   = RW + OUT_W;
	localparam int DL    = OUT_W + 1;
	localparam int LAT_P = 7 + RW + DL;

	typedef struct packed {
		logic [ZW-1:0] z0;
		logic [ZW-1:0] z1;
		logic [ZW-1:0] z2;
		logic [2:0]    neg;
		logic          degen;
	} side_t;

	typedef struct packed {
		logic [RW-1:0] root;
		logic [2:0]    neg;
		logic          degen;
	} fin_t;

	logic adv;
	logic vld_s [1:LAT_P];

	logic signed [CW-1:0]  p [3][3];
	logic signed [EW-1:0]  e_s1 [3][3];
	logic signed [PW-1:0]  cpa_s2 [3], cpb_s2 [3];
	logic signed [PW-1:0]  sp_s2 [3][3], dp_s2 [3][3];
	logic signed [CRW-1:0] cr_s3 [3];
	logic signed [DTW-1:0] sq_s3 [3], dot_s3 [3];
	logic [MW-1:0]         crm_s4 [3], sqm_s4 [3], dm_s4 [3];
	logic [2:0]            neg_s4, neg_s5, neg_s6;
	logic                  degen_s4, degen_s5, degen_s6;
	logic [CRW-1:0]        cr_abs [3];
	logic [DTW-1:0]        dot_abs [3];
	logic [2*MW-1:0]       pr_s6 [3];
	logic [2*MW-1:0]       pa_s6, pb_s6, pc_s6;
	logic [NUMW-1:0]       num0, num1, num2;

	logic [QW-1:0] rt_rem_s  [0:RW];
	logic [RW-1:0] rt_root_s [0:RW];
	side_t         sd_s [0:RW];
	fin_t          fd_s [1:DL];
	logic [OUT_W-1:0] quo0, quo1, quo2;

	logic [NXW-1:0]   nx, ax, hx, qx;
	logic [OUT_W-1:0] area_w, half_w, quart_w;
	logic [4*OUT_W-1:0] res_data;
	logic [2:0]         res_user;
	corner_t            obt;

	logic [4*OUT_W-1:0] out_data_q, skd_data_q;
	logic [2:0]         out_user_q, skd_user_q;
	logic               out_vld_q, skd_vld_q, out_take;

	// pipeline advances whenever the skid is free
	assign adv           = ~skd_vld_q;
	assign s_axis_tready = adv;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAT_P; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int j = 2; j <= LAT_P; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// unpack vertex coordinates
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				p[i][k] = $signed(s_axis_tdata[(3*i+k)*CW +: CW]);
	end

	// stage 1: edge vectors
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e_s1[0][k] <= EW'(p[1][k]) - EW'(p[0][k]);
				e_s1[1][k] <= EW'(p[2][k]) - EW'(p[1][k]);
				e_s1[2][k] <= EW'(p[0][k]) - EW'(p[2][k]);
			end
		end
	end

	// stage 2: all coordinate products
	always_ff @(posedge clk) begin
		if (adv) begin
			cpa_s2[0] <= e_s1[0][1] * e_s1[1][2];
			cpb_s2[0] <= e_s1[0][2] * e_s1[1][1];
			cpa_s2[1] <= e_s1[0][2] * e_s1[1][0];
			cpb_s2[1] <= e_s1[0][0] * e_s1[1][2];
			cpa_s2[2] <= e_s1[0][0] * e_s1[1][1];
			cpb_s2[2] <= e_s1[0][1] * e_s1[1][0];
			for (int k = 0; k < 3; k++) begin
				sp_s2[0][k] <= e_s1[0][k] * e_s1[0][k];
				sp_s2[1][k] <= e_s1[1][k] * e_s1[1][k];
				sp_s2[2][k] <= e_s1[2][k] * e_s1[2][k];
				// corner i sits between incoming edge i+2 and outgoing edge i
				dp_s2[0][k] <= e_s1[2][k] * e_s1[0][k];
				dp_s2[1][k] <= e_s1[0][k] * e_s1[1][k];
				dp_s2[2][k] <= e_s1[1][k] * e_s1[2][k];
			end
		end
	end

	// stage 3: cross product, squared edge lengths, corner dot products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cr_s3[i]  <= CRW'(cpa_s2[i]) - CRW'(cpb_s2[i]);
				sq_s3[i]  <= DTW'(sp_s2[i][0]) + DTW'(sp_s2[i][1]) + DTW'(sp_s2[i][2]);
				dot_s3[i] <= DTW'(dp_s2[i][0]) + DTW'(dp_s2[i][1]) + DTW'(dp_s2[i][2]);
			end
		end
	end

	// magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr_abs[i]  = cr_s3[i][CRW-1] ? CRW'(-cr_s3[i]) : CRW'(cr_s3[i]);
			dot_abs[i] = dot_s3[i][DTW-1] ? DTW'(-dot_s3[i]) : DTW'(dot_s3[i]);
		end
	end

	// stage 4: magnitudes, obtuse flags (dot > 0 means an angle over 90 deg)
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				crm_s4[i] <= cr_abs[i][MW-1:0];
				sqm_s4[i] <= sq_s3[i][MW-1:0];
				dm_s4[i]  <= dot_abs[i][MW-1:0];
				neg_s4[i] <= ~dot_s3[i][DTW-1] & (dot_s3[i] != '0);
			end
			degen_s4 <= (cr_s3[0] == '0) && (cr_s3[1] == '0) && (cr_s3[2] == '0);
		end
	end

	// stages 5 and 6: wide products
	for (genvar k = 0; k < 3; k++) begin : g_sqr
		mvtw_mul #(.W(MW)) u_sqr (
			.clk (clk), .en (adv), .a (crm_s4[k]), .b (crm_s4[k]), .p (pr_s6[k])
		);
	end

	mvtw_mul #(.W(MW)) u_mul_a (.clk(clk), .en(adv), .a(sqm_s4[0]), .b(dm_s4[2]), .p(pa_s6));
	mvtw_mul #(.W(MW)) u_mul_b (.clk(clk), .en(adv), .a(sqm_s4[2]), .b(dm_s4[1]), .p(pb_s6));
	mvtw_mul #(.W(MW)) u_mul_c (.clk(clk), .en(adv), .a(sqm_s4[1]), .b(dm_s4[0]), .p(pc_s6));

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
		end
	end

	// weight numerators, each shared product used by two corners
	assign num0 = NUMW'(pa_s6) + NUMW'(pb_s6);
	assign num1 = NUMW'(pc_s6) + NUMW'(pa_s6);
	assign num2 = NUMW'(pb_s6) + NUMW'(pc_s6);

	// stage 7: squared double area, pre-scaled numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			rt_rem_s[0]  <= QW'(pr_s6[0]) + QW'(pr_s6[1]) + QW'(pr_s6[2]);
			rt_root_s[0] <= '0;
			sd_s[0].z0    <= num0[NUMW-1:F+3];
			sd_s[0].z1    <= num1[NUMW-1:F+3];
			sd_s[0].z2    <= num2[NUMW-1:F+3];
			sd_s[0].neg   <= neg_s6;
			sd_s[0].degen <= degen_s6;
		end
	end

	// integer square root, one root bit per stage
	for (genvar j = 1; j <= RW; j++) begin : g_root
		localparam int K = RW - j;
		logic [QW-1:0] trial;
		logic          fits;

		assign trial = (QW'(rt_root_s[j-1]) << (K + 1)) | (QW'(1) << (2 * K));
		assign fits  = rt_rem_s[j-1] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[j]  <= fits ? rt_rem_s[j-1] - trial : rt_rem_s[j-1];
				rt_root_s[j] <= rt_root_s[j-1] | (fits ? (RW'(1) << K) : '0);
				sd_s[j]      <= sd_s[j-1];
			end
		end
	end

	// weight quotients
	mvtw_div #(.ZW(ZW), .DW(RW)) u_div0 (
		.clk (clk), .en (adv), .num (sd_s[RW].z0), .den (rt_root_s[RW]), .quo (quo0)
	);
	mvtw_div #(.ZW(ZW), .DW(RW)) u_div1 (
		.clk (clk), .en (adv), .num (sd_s[RW].z1), .den (rt_root_s[RW]), .quo (quo1)
	);
	mvtw_div #(.ZW(ZW), .DW(RW)) u_div2 (
		.clk (clk), .en (adv), .num (sd_s[RW].z2), .den (rt_root_s[RW]), .quo (quo2)
	);

	// root and flags ride alongside the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s[1].root  <= rt_root_s[RW];
			fd_s[1].neg   <= sd_s[RW].neg;
			fd_s[1].degen <= sd_s[RW].degen;
			for (int j = 2; j <= DL; j++) fd_s[j] <= fd_s[j-1];
		end
	end

	// result selection and saturation
	always_comb begin
		nx      = NXW'(fd_s[DL].root);
		ax      = nx >> (F + 1);
		hx      = nx >> (F + 2);
		qx      = nx >> (F + 3);
		area_w  = (|ax[NXW-1:OUT_W]) ? '1 : ax[OUT_W-1:0];
		half_w  = (|hx[NXW-1:OUT_W]) ? '1 : hx[OUT_W-1:0];
		quart_w = (|qx[NXW-1:OUT_W]) ? '1 : qx[OUT_W-1:0];

		if (fd_s[DL].neg[0])      obt = CORNER_0;
		else if (fd_s[DL].neg[1]) obt = CORNER_1;
		else if (fd_s[DL].neg[2]) obt = CORNER_2;
		else                      obt = CORNER_NONE;

		if (fd_s[DL].degen) begin
			res_data = '0;
			res_user = {1'b1, CORNER_NONE};
		end else if (obt != CORNER_NONE) begin
			res_data = {fd_s[DL].neg[2] ? half_w : quart_w,
				fd_s[DL].neg[1] ? half_w : quart_w,
				fd_s[DL].neg[0] ? half_w : quart_w, area_w};
			res_user = {1'b0, obt};
		end else begin
			res_data = {quo2, quo1, quo0, area_w};
			res_user = {1'b0, obt};
		end
	end

	// output register plus skid entry
	assign out_take = ~out_vld_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (out_take) begin
				out_vld_q <= 1'b1;
				skd_vld_q <= 1'b0;
			end
		end else if (vld_s[LAT_P]) begin
			if (out_take) out_vld_q <= 1'b1;
			else          skd_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skd_vld_q) begin
			if (out_take) begin
				out_data_q <= skd_data_q;
				out_user_q <= skd_user_q;
			end
		end else if (vld_s[LAT_P]) begin
			if (out_take) begin
				out_data_q <= res_data;
				out_user_q <= res_user;
			end else begin
				skd_data_q <= res_data;
				skd_user_q <= res_user;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

>>> hw/rtl/mvtw_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the mixed Voronoi triangle weight block, bound to the top.
// Depends on mvtw_pkg and the assertion macro header.
`include "mixed_voronoi_triangle_weights_macros.svh"
module mvtw_port_checks (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [4*mvtw_pkg::OUT_W-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);
	import mvtw_pkg::*;

	logic [OUT_W-1:0] area, w0, w1, w2;
	logic             degen, obt0, stall;

	assign area  = m_axis_tdata[OUT_W-1:0];
	assign w0    = m_axis_tdata[2*OUT_W-1:OUT_W];
	assign w1    = m_axis_tdata[3*OUT_W-1:2*OUT_W];
	assign w2    = m_axis_tdata[4*OUT_W-1:3*OUT_W];
	assign degen = m_axis_tuser[2];
	assign obt0  = m_axis_tvalid && !degen && (m_axis_tuser[1:0] == CORNER_0) && (area != '1);
	assign stall = m_axis_tvalid && !m_axis_tready;

	// a pending result stays offered
	`MVTW_ASSERT_NXT(a_out_hold, clk, arst_n, stall, m_axis_tvalid)
	// and its payload does not move
	`MVTW_ASSERT_NXT(a_out_stable, clk, arst_n, stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// input back-pressure only while a result is waiting
	`MVTW_ASSERT_IMP(a_ready_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid)
	// flat triangle gives zeros and no obtuse corner
	`MVTW_ASSERT_IMP(a_degen_zero, clk, arst_n, m_axis_tvalid && degen, (m_axis_tdata == '0) && (m_axis_tuser[1:0] == CORNER_NONE))
	// obtuse at corner 0 with the area not saturated: half the area there, a quarter elsewhere
	`MVTW_ASSERT_IMP(a_obtuse_split, clk, arst_n, obt0, (w0 == (area >> 1)) && (w1 == (area >> 2)) && (w2 == (area >> 2)))

endmodule

bind mixed_voronoi_triangle_weights mvtw_port_checks u_mvtw_port_checks (.*);
